>>> src/bis_pkg.sv
`timescale 1ns / 1ps
package bis_pkg;

  localparam int MAX_SRC_COLS_D = 512;
  localparam int MAX_SRC_ROWS_D = 512;
  localparam int MAX_DST_DIM_D  = 4096;

  localparam int CFG_W  = 13;
  localparam int CFG_IW = 2;

  // Register indexes
  localparam logic [CFG_IW-1:0] REG_SRC_COLS = 2'd0;
  localparam logic [CFG_IW-1:0] REG_SRC_ROWS = 2'd1;
  localparam logic [CFG_IW-1:0] REG_DST_COLS = 2'd2;
  localparam logic [CFG_IW-1:0] REG_DST_ROWS = 2'd3;

  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_COMPUTE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [11:0] col;
    logic [11:0] row;
    logic [7:0]  pixel;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       range_error;
  } out_item_t;

  // Step divider status toward the top level
  typedef struct packed {
    logic        busy;
    logic [25:0] col_step;
    logic [25:0] row_step;
  } step_stat_t;

endpackage

>>> src/bis_step_div.sv
`timescale 1ns / 1ps
// Recomputes col_step and row_step with a restoring divider, one quotient
// bit per cycle, both axes at once.
module bis_step_div #(
  parameter int MAX_SRC_COLS = bis_pkg::MAX_SRC_COLS_D,
  parameter int MAX_SRC_ROWS = bis_pkg::MAX_SRC_ROWS_D,
  parameter int MAX_DST_DIM  = bis_pkg::MAX_DST_DIM_D
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                kick,
  input  logic [9:0]          src_cols,
  input  logic [9:0]          src_rows,
  input  logic [12:0]         dst_cols,
  input  logic [12:0]         dst_rows,
  output bis_pkg::step_stat_t stat
);
  import bis_pkg::*;

  localparam int NW = 42;   // dividend width: (src-1)<<16 fits
  localparam int DW = 16;

  logic [NW-1:0] cnum, rnum;
  logic [DW:0]   crem, rrem;
  logic [DW-1:0] cden, rden;
  logic [5:0]    cnt;
  logic          run;
  logic [25:0]   cq, rq;

  function automatic logic [DW-1:0] clampd(input logic [12:0] v, input int hi);
    logic [DW-1:0] r;
    r = {{(DW-13){1'b0}}, v};
    if (r < 2) r = DW'(2);
    else if (r > DW'(hi)) r = DW'(hi);
    return r;
  endfunction

  logic [DW:0] cr_sh, rr_sh;
  assign cr_sh = {crem[DW-1:0], cnum[NW-1]};
  assign rr_sh = {rrem[DW-1:0], rnum[NW-1]};

  always_ff @(posedge clk) begin
    if (rst || kick) begin
      run  <= 1'b1;
      cnt  <= 6'(NW);
      crem <= '0;
      rrem <= '0;
      cnum <= NW'(clampd({3'b0, src_cols}, MAX_SRC_COLS) - 1) << 16;
      rnum <= NW'(clampd({3'b0, src_rows}, MAX_SRC_ROWS) - 1) << 16;
      cden <= clampd(dst_cols, MAX_DST_DIM) - 1'b1;
      rden <= clampd(dst_rows, MAX_DST_DIM) - 1'b1;
      if (rst) begin
        cq <= '0;
        rq <= '0;
      end
    end else if (run) begin
      cnum <= cnum << 1;
      rnum <= rnum << 1;
      if (cr_sh >= {1'b0, cden}) begin
        crem <= cr_sh - {1'b0, cden};
        cq   <= {cq[24:0], 1'b1};
      end else begin
        crem <= cr_sh;
        cq   <= {cq[24:0], 1'b0};
      end
      if (rr_sh >= {1'b0, rden}) begin
        rrem <= rr_sh - {1'b0, rden};
        rq   <= {rq[24:0], 1'b1};
      end else begin
        rrem <= rr_sh;
        rq   <= {rq[24:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) run <= 1'b0;
    end
  end

  assign stat.busy     = run;
  assign stat.col_step = cq;
  assign stat.row_step = rq;

endmodule

>>> src/bis_store.sv
`timescale 1ns / 1ps
// Source image in four banks split by row and column parity, so the four
// neighbours of any point come out in the same cycle. The read is registered.
module bis_store #(
  parameter int MAX_SRC_COLS = bis_pkg::MAX_SRC_COLS_D,
  parameter int MAX_SRC_ROWS = bis_pkg::MAX_SRC_ROWS_D,
  parameter int XW = $clog2(MAX_SRC_COLS),
  parameter int YW = $clog2(MAX_SRC_ROWS)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [XW-1:0] wr_x,
  input  logic [YW-1:0] wr_y,
  input  logic [7:0]    wr_data,
  input  logic [XW-1:0] x1,
  input  logic [XW-1:0] x2,
  input  logic [YW-1:0] y1,
  input  logic [YW-1:0] y2,
  output logic [7:0]    p11,
  output logic [7:0]    p21,
  output logic [7:0]    p12,
  output logic [7:0]    p22
);
  import bis_pkg::*;

  localparam int HX = (MAX_SRC_COLS + 1) / 2;
  localparam int HY = (MAX_SRC_ROWS + 1) / 2;
  localparam int HXW = (XW > 1) ? XW - 1 : 1;
  localparam int HYW = (YW > 1) ? YW - 1 : 1;
  localparam int DEPTH = HX * HY;
  localparam int AW = HXW + HYW;

  logic [7:0] b00 [DEPTH];
  logic [7:0] b01 [DEPTH];
  logic [7:0] b10 [DEPTH];
  logic [7:0] b11 [DEPTH];

  // Per-bank column/row pick by parity
  logic [XW-1:0] xe, xo;
  logic [YW-1:0] ye, yo;
  logic          sx, sy;
  always_comb begin
    xe = x1[0] ? x2 : x1;
    xo = x1[0] ? x1 : x2;
    ye = y1[0] ? y2 : y1;
    yo = y1[0] ? y1 : y2;
  end

  function automatic logic [AW-1:0] addr(input logic [YW-1:0] y, input logic [XW-1:0] x);
    return {HYW'(y >> 1), HXW'(x >> 1)};
  endfunction

  logic [AW-1:0] wa;
  assign wa = addr(wr_y, wr_x);

  logic [7:0] r00, r01, r10, r11;
  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case ({wr_y[0], wr_x[0]})
        2'b00:   b00[wa] <= wr_data;
        2'b01:   b01[wa] <= wr_data;
        2'b10:   b10[wa] <= wr_data;
        default: b11[wa] <= wr_data;
      endcase
    end
    r00 <= b00[addr(ye, xe)];
    r01 <= b01[addr(ye, xo)];
    r10 <= b10[addr(yo, xe)];
    r11 <= b11[addr(yo, xo)];
    sx  <= x1[0];
    sy  <= y1[0];
  end

  // Map banks back to neighbour positions
  always_comb begin
    logic [7:0] ye_x1, ye_x2, yo_x1, yo_x2;
    ye_x1 = sx ? r01 : r00;
    ye_x2 = sx ? r00 : r01;
    yo_x1 = sx ? r11 : r10;
    yo_x2 = sx ? r10 : r11;
    p11 = sy ? yo_x1 : ye_x1;
    p21 = sy ? yo_x2 : ye_x2;
    p12 = sy ? ye_x1 : yo_x1;
    p22 = sy ? ye_x2 : yo_x2;
  end

endmodule

>>> src/bis_blend.sv
`timescale 1ns / 1ps
// Weight and blend pipeline: column-weight products one stage, row-weight
// products the next, sum, rounding and saturation last.
module bis_blend (
  input  logic                clk,
  input  logic                rst,
  input  logic                vin,
  input  logic                err_in,
  input  logic [16:0]         p,
  input  logic [16:0]         q,
  input  logic [7:0]          p11,
  input  logic [7:0]          p21,
  input  logic [7:0]          p12,
  input  logic [7:0]          p22,
  output logic                vout,
  output bis_pkg::out_item_t  item
);
  import bis_pkg::*;

  logic [16:0] pi, qi;
  assign pi = 17'h10000 - p;
  assign qi = 17'h10000 - q;

  // Stage 1: pixel times the column weight
  logic        v1, e1;
  logic [24:0] a11, a21, a12, a22;
  logic [16:0] q1, qi1;
  always_ff @(posedge clk) begin
    v1  <= rst ? 1'b0 : vin;
    e1  <= err_in;
    a11 <= 25'(pi) * 25'(p11);
    a21 <= 25'(p)  * 25'(p21);
    a12 <= 25'(pi) * 25'(p12);
    a22 <= 25'(p)  * 25'(p22);
    q1  <= q;
    qi1 <= qi;
  end

  // Stage 2: row weight
  logic        v2, e2;
  logic [41:0] m1, m2;
  always_ff @(posedge clk) begin
    v2 <= rst ? 1'b0 : v1;
    e2 <= e1;
    m1 <= 42'(a11 + a21) * 42'(qi1);
    m2 <= 42'(a12 + a22) * 42'(q1);
  end

  // Stage 3: sum, round, saturate
  logic [42:0] s;
  always_comb s = 43'(m1) + 43'(m2) + 43'h80000000;
  always_ff @(posedge clk) begin
    vout <= rst ? 1'b0 : v2;
    item.range_error <= e2;
    if (e2) item.pixel_out <= '0;
    else if (s[42:32] > 11'd255) item.pixel_out <= 8'hFF;
    else item.pixel_out <= s[39:32];
  end

endmodule

>>> src/bilinear_image_scaler_unit.sv
`timescale 1ns / 1ps
// Bilinear image scaler, corner-aligned, 8-bit gray.
// Items enter on start/cmd when busy is low. func load writes one source
// pixel into a four-bank store (loads outside the source size are dropped);
// func compute returns one destination pixel on result/done.
// Throughput: one item per cycle while busy is low. A compute result passes
// the address stage, store read and three blend stages, then shows up on done
// for one cycle; the receiver cannot stall, results are never held.
// Configuration: cfg_we/cfg_addr/cfg_data write a register at once. Each
// write raises busy the next cycle, first to launch the step divider, then
// while it computes its quotient bits (one a cycle). Write only while idle.
// Reset: registers return to 512x512 -> 1024x1024 and busy is high for the
// step computation. The image store is not cleared; pixels read before
// being loaded are undefined.
// A load followed by a compute reading that pixel in the next cycle sees the
// new value: the store write lands before the store read samples the banks.
module bilinear_image_scaler_unit #(
  parameter int MAX_SRC_COLS = bis_pkg::MAX_SRC_COLS_D,
  parameter int MAX_SRC_ROWS = bis_pkg::MAX_SRC_ROWS_D,
  parameter int MAX_DST_DIM  = bis_pkg::MAX_DST_DIM_D
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bis_pkg::in_item_t             cmd,
  output logic                          done,
  output bis_pkg::out_item_t            result,
  input  logic                          cfg_we,
  input  logic [bis_pkg::CFG_IW-1:0]    cfg_addr,
  input  logic [bis_pkg::CFG_W-1:0]     cfg_data
);
  import bis_pkg::*;

  localparam int XW = $clog2(MAX_SRC_COLS);
  localparam int YW = $clog2(MAX_SRC_ROWS);

  logic [9:0]  src_cols, src_rows;
  logic [12:0] dst_cols, dst_rows;
  step_stat_t  st;

  // Config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      src_cols <= 10'd512;
      src_rows <= 10'd512;
      dst_cols <= 13'd1024;
      dst_rows <= 13'd1024;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SRC_COLS: src_cols <= cfg_data[9:0];
        REG_SRC_ROWS: src_rows <= cfg_data[9:0];
        REG_DST_COLS: dst_cols <= cfg_data;
        default:      dst_rows <= cfg_data;
      endcase
    end
  end

  logic kick;
  always_ff @(posedge clk) kick <= rst ? 1'b0 : cfg_we;

  bis_step_div #(
    .MAX_SRC_COLS(MAX_SRC_COLS), .MAX_SRC_ROWS(MAX_SRC_ROWS),
    .MAX_DST_DIM(MAX_DST_DIM)
  ) u_div (
    .clk, .rst, .kick, .src_cols, .src_rows, .dst_cols, .dst_rows, .stat(st)
  );

  assign busy = st.busy | kick;

  // Effective sizes
  logic [12:0] sc, sr, dc, dr;
  always_comb begin
    sc = (src_cols < 2) ? 13'd2 : (13'(src_cols) > 13'(MAX_SRC_COLS)) ?
         13'(MAX_SRC_COLS) : 13'(src_cols);
    sr = (src_rows < 2) ? 13'd2 : (13'(src_rows) > 13'(MAX_SRC_ROWS)) ?
         13'(MAX_SRC_ROWS) : 13'(src_rows);
    dc = (dst_cols < 2) ? 13'd2 : (15'(dst_cols) > 15'(MAX_DST_DIM)) ?
         13'(MAX_DST_DIM) : dst_cols;
    dr = (dst_rows < 2) ? 13'd2 : (15'(dst_rows) > 15'(MAX_DST_DIM)) ?
         13'(MAX_DST_DIM) : dst_rows;
  end

  logic acc;
  assign acc = start & ~busy;

  // Stage A: load write path and coordinate products
  logic        wr_en;
  logic [XW-1:0] wr_x;
  logic [YW-1:0] wr_y;
  logic [7:0]  wr_d;
  logic        va, ea;
  logic [37:0] rx, ry;
  always_ff @(posedge clk) begin
    wr_en <= ~rst & acc & (cmd.func == FUNC_LOAD) &
             (13'(cmd.col) < sc) & (13'(cmd.row) < sr);
    wr_x  <= XW'(cmd.col);
    wr_y  <= YW'(cmd.row);
    wr_d  <= cmd.pixel;
    va    <= ~rst & acc & (cmd.func == FUNC_COMPUTE);
    ea    <= (13'(cmd.col) >= dc) | (13'(cmd.row) >= dr);
    rx    <= 38'(cmd.col) * 38'(st.col_step);
    ry    <= 38'(cmd.row) * 38'(st.row_step);
  end

  // Neighbour coordinates, clamped
  logic [21:0] x1w, y1w;
  logic [12:0] x1c, y1c, x2c, y2c;
  always_comb begin
    x1w = rx[37:16];
    y1w = ry[37:16];
    x1c = (x1w > 22'(sc - 1'b1)) ? sc - 1'b1 : 13'(x1w);
    y1c = (y1w > 22'(sr - 1'b1)) ? sr - 1'b1 : 13'(y1w);
    x2c = (x1c + 1'b1 >= sc) ? sc - 1'b1 : x1c + 1'b1;
    y2c = (y1c + 1'b1 >= sr) ? sr - 1'b1 : y1c + 1'b1;
  end

  logic [7:0] p11, p21, p12, p22;
  bis_store #(
    .MAX_SRC_COLS(MAX_SRC_COLS), .MAX_SRC_ROWS(MAX_SRC_ROWS), .XW(XW), .YW(YW)
  ) u_store (
    .clk, .wr_en, .wr_x, .wr_y, .wr_data(wr_d),
    .x1(XW'(x1c)), .x2(XW'(x2c)), .y1(YW'(y1c)), .y2(YW'(y2c)),
    .p11, .p21, .p12, .p22
  );

  // Stage B: align fractions with store read
  logic        vb, eb;
  logic [16:0] pb, qb;
  always_ff @(posedge clk) begin
    vb <= rst ? 1'b0 : va;
    eb <= ea;
    pb <= {1'b0, rx[15:0]};
    qb <= {1'b0, ry[15:0]};
  end

  bis_blend u_blend (
    .clk, .rst, .vin(vb), .err_in(eb), .p(pb), .q(qb),
    .p11, .p21, .p12, .p22, .vout(done), .item(result)
  );

endmodule

>>> src/bis_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the scaler.
module bis_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input bis_pkg::out_item_t result,
  input logic               cfg_we
);
  import bis_pkg::*;

  // A range error always carries pixel 0
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.range_error |-> result.pixel_out == 8'd0)
    else $error("range error with nonzero pixel");

  // Config write makes the block busy once the step divider runs
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> ##1 busy)
    else $error("not busy after config write");

  // No result without an item accepted a pipeline depth earlier
  a_no_spur: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 5))
    else $error("result without item");

  // Busy right after reset
  a_rst_busy: assert property (@(posedge clk)
    $fell(rst) |-> busy)
    else $error("not busy after reset");

endmodule

bind bilinear_image_scaler_unit bis_checker u_chk (
  .clk, .rst, .start, .busy, .done, .result, .cfg_we
);
